### sv/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// shared types and constants for the point in polygon crossing test
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int COORD_BITS       = 16;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                          action;
        logic signed [COORD_BITS-1:0]  coord_x;
        logic signed [COORD_BITS-1:0]  coord_y;
        logic                          last;
    } t_in_item;

    typedef struct packed {
        logic inside_res;
        logic overflow;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic issue;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic issue_last;
        logic pipe_busy;
        logic out_busy;
    } t_sts;

endpackage

### sv/pip_ctrl.sv
// ----------------------------------------------------------------------------
// pip_ctrl
// sequencer for vertex loads and the edge walk of a query
// ----------------------------------------------------------------------------
module pip_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_action,
    output logic          o_in_ready,
    input  pip_pkg::t_sts i_sts,
    output pip_pkg::t_cmd o_cmd
);
    import pip_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_action == ACT_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = i_sts.count_zero ? S_DONE : S_WALK;
                    end
                end
            end
            S_WALK: begin
                o_cmd.issue = 1'b1;
                if (i_sts.issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/pip_dpath.sv
// ----------------------------------------------------------------------------
// pip_dpath
// vertex store, edge pipeline and crossing parity with output register
// ----------------------------------------------------------------------------
module pip_dpath #(
    parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pip_pkg::t_cmd     i_cmd,
    output pip_pkg::t_sts     o_sts,
    input  pip_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pip_pkg::t_out_item o_out_data
);
    import pip_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;
    localparam int PW = 2 * DW;

    logic [C-1:0]  r_mem_x [MAX_VERTICES];
    logic [C-1:0]  r_mem_y [MAX_VERTICES];

    logic [CW-1:0] r_count;
    logic          r_closed;
    logic          r_ovf;
    logic [CW-1:0] w_eff_count;
    logic          w_full;

    logic signed [C-1:0] r_px;
    logic signed [C-1:0] r_py;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_last_addr;
    logic          r_prime;

    logic          r_rd_go;
    logic          r_rd_edge;
    logic signed [C-1:0] r_rd_x;
    logic signed [C-1:0] r_rd_y;
    logic signed [C-1:0] r_prv_x;
    logic signed [C-1:0] r_prv_y;

    logic signed [DW-1:0] w_dyi;
    logic signed [DW-1:0] w_dxji;
    logic signed [DW-1:0] w_dxp;
    logic signed [DW-1:0] w_dy;
    logic                 w_straddle;
    logic                 w_left_of;

    logic                 r_c_vld;
    logic                 r_c_en;
    logic                 r_c_dypos;
    logic signed [PW-1:0] r_left;
    logic signed [PW-1:0] r_right;
    logic                 w_hit;

    logic                 r_odd;
    logic                 r_out_vld;
    t_out_item            r_out;

    // vertex store and load bookkeeping
    assign w_eff_count = r_closed ? '0 : r_count;
    assign w_full      = (w_eff_count >= CW'(MAX_VERTICES));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !w_full) begin
            r_mem_x[w_eff_count[AW-1:0]] <= i_in_data.coord_x;
            r_mem_y[w_eff_count[AW-1:0]] <= i_in_data.coord_y;
        end
        if (i_cmd.issue) begin
            r_rd_x <= r_mem_x[r_addr];
            r_rd_y <= r_mem_y[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_closed <= 1'b0;
            r_ovf    <= 1'b0;
        end else if (i_cmd.load) begin
            r_closed <= i_in_data.last;
            if (w_full) begin
                r_count <= w_eff_count;
                r_ovf   <= 1'b1;
            end else begin
                r_count <= w_eff_count + 1'b1;
                r_ovf   <= r_closed ? 1'b0 : r_ovf;
            end
        end
    end

    // read address walk: vertex n-1 first, then 0 .. n-1
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_px        <= i_in_data.coord_x;
            r_py        <= i_in_data.coord_y;
            r_addr      <= AW'(r_count - 1'b1);
            r_last_addr <= AW'(r_count - 1'b1);
        end else if (i_cmd.issue) begin
            r_addr <= r_prime ? '0 : r_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime   <= 1'b0;
            r_rd_go   <= 1'b0;
            r_rd_edge <= 1'b0;
            r_c_vld   <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_prime <= 1'b1;
            end else if (i_cmd.issue) begin
                r_prime <= 1'b0;
            end
            r_rd_go   <= i_cmd.issue;
            r_rd_edge <= i_cmd.issue && !r_prime;
            r_c_vld   <= r_rd_edge;
        end
    end

    // edge stage: vertex i in r_rd, vertex j in r_prv
    assign w_dyi  = {r_py[C-1], r_py} - {r_rd_y[C-1], r_rd_y};
    assign w_dxji = {r_prv_x[C-1], r_prv_x} - {r_rd_x[C-1], r_rd_x};
    assign w_dxp  = {r_px[C-1], r_px} - {r_rd_x[C-1], r_rd_x};
    assign w_dy   = {r_prv_y[C-1], r_prv_y} - {r_rd_y[C-1], r_rd_y};

    assign w_straddle = ((r_rd_y < r_py) && (r_prv_y >= r_py))
                     || ((r_prv_y < r_py) && (r_rd_y >= r_py));
    assign w_left_of  = (r_rd_x <= r_px) || (r_prv_x <= r_px);

    always_ff @(posedge i_clk) begin
        if (r_rd_go) begin
            r_prv_x <= r_rd_x;
            r_prv_y <= r_rd_y;
        end
        if (r_rd_edge) begin
            r_c_en    <= w_straddle && w_left_of;
            r_c_dypos <= !w_dy[DW-1];
            r_left    <= w_dyi * w_dxji;
            r_right   <= w_dxp * w_dy;
        end
    end

    // compare stage and parity
    assign w_hit = r_c_dypos ? (r_left < r_right) : (r_left > r_right);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_odd <= 1'b0;
        end else if (r_c_vld && r_c_en && w_hit) begin
            r_odd <= !r_odd;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.inside_res <= r_odd;
            r_out.overflow   <= r_ovf;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.issue_last = !r_prime && (r_addr == r_last_addr);
    assign o_sts.pipe_busy  = r_rd_go || r_c_vld;
    assign o_sts.out_busy   = r_out_vld && !i_out_ready;

endmodule

### sv/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test
// even-odd crossing test of a point against a stored polygon
// ----------------------------------------------------------------------------
// input channel (i_in_valid / o_in_ready / i_in_data): a transaction with
// action load appends one vertex; last closes the polygon and the next load
// starts a new one. vertices past MAX_VERTICES are dropped and flag overflow.
// a load gives no result.
// a transaction with action query walks all n stored edges through one
// read port of the vertex store, one edge per cycle, and returns one result
// on the output channel (o_out_valid / i_out_ready / o_out_data).
// a query result follows the edge walk once the read port of the vertex
// store and the two-stage multiply/compare pipeline have drained (an empty
// store skips the walk); the next transaction is taken in the same cycle
// that o_out_valid rises.
// a finished result sits in an output register; if the receiver stalls,
// loads are still taken and only the next query result waits for the slot.
// reset clears the vertex count, closed and overflow flags, the pipeline valids
// and the output valid; the vertex store itself is not cleared.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
    parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pip_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pip_pkg::t_out_item o_out_data
);
    import pip_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    pip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pip_dpath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.start, w_cmd.issue, w_cmd.finish}))
        else $error("more than one datapath command at once");

    a_query_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.action == ACT_QUERY) |=> !o_in_ready)
        else $error("transaction accepted during a query walk");

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_sts.pipe_busy)
        else $error("edge pipeline busy while idle");

    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> o_out_valid)
        else $error("query result lost");

endmodule

### bench/pip_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pip_checker
// watches both channels of point_in_polygon_test, keeps its own copy of the
// vertex store, predicts every query result by the even-odd crossing rule
// with exact cross-multiplication and compares field by field in order
// ----------------------------------------------------------------------------
module pip_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  pip_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  pip_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import pip_pkg::*;

    localparam int DEPTH = DEF_MAX_VERTICES;

    logic signed [COORD_BITS-1:0] poly_x [DEPTH];
    logic signed [COORD_BITS-1:0] poly_y [DEPTH];
    int unsigned                  n_vert;
    bit                           poly_closed;
    bit                           poly_dropped;
    t_out_item                    expected_q [$];

    function automatic bit even_odd_inside(input logic signed [COORD_BITS-1:0] px,
                                           input logic signed [COORD_BITS-1:0] py);
        bit          odd;
        int unsigned j;
        longint      qx, qy, xi, yi, xj, yj, lhs, rhs;
        odd = 1'b0;
        qx  = px;
        qy  = py;
        if (n_vert == 0) begin
            return 1'b0;
        end
        j = n_vert - 1;
        for (int unsigned i = 0; i < n_vert; i++) begin
            xi = poly_x[i];
            yi = poly_y[i];
            xj = poly_x[j];
            yj = poly_y[j];
            if (((yi < qy && yj >= qy) || (yj < qy && yi >= qy)) && (xi <= qx || xj <= qx)) begin
                lhs = (qy - yi) * (xj - xi);
                rhs = (qx - xi) * (yj - yi);
                if ((yj > yi) ? (lhs < rhs) : (lhs > rhs)) begin
                    odd = !odd;
                end
            end
            j = i;
        end
        return odd;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            o_fail_count = 0;
            n_vert       = 0;
            poly_closed  = 1'b0;
            poly_dropped = 1'b0;
            expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_q.size() == 0) begin
                    $display("%0t: result transaction with none pending: inside_res %b overflow %b",
                             $time, got.inside_res, got.overflow);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.inside_res !== want.inside_res) begin
                        $display("%0t: inside_res expected %b actual %b",
                                 $time, want.inside_res, got.inside_res);
                        o_fail_count++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $display("%0t: overflow expected %b actual %b",
                                 $time, want.overflow, got.overflow);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.action == ACT_LOAD) begin
                    if (poly_closed) begin
                        n_vert       = 0;
                        poly_dropped = 1'b0;
                        poly_closed  = 1'b0;
                    end
                    if (n_vert < DEPTH) begin
                        poly_x[n_vert] = i_in_data.coord_x;
                        poly_y[n_vert] = i_in_data.coord_y;
                        n_vert++;
                    end else begin
                        poly_dropped = 1'b1;
                    end
                    if (i_in_data.last) begin
                        poly_closed = 1'b1;
                    end
                end else begin
                    want.inside_res = even_odd_inside(i_in_data.coord_x, i_in_data.coord_y);
                    want.overflow   = poly_dropped;
                    expected_q.insert(expected_q.size(), want);
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

### bench/tb_point_in_polygon_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_in_polygon_test
// stimulus and verdict for the point in polygon crossing test: a directed set
// of extreme and boundary points, then random polygons of varied size and
// scale (including overflowing ones) followed by queries, with random stalls
// on both channels; all checking happens in pip_checker
// ----------------------------------------------------------------------------
module tb_point_in_polygon_test;
    import pip_pkg::*;

    localparam int N_ITEMS = 1050;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;

    int fail_count;
    int pending;

    bit hold_req;
    int rx_cycle;
    int items_sent;
    int n_loads;
    int n_queries;
    int n_polys;
    int n_overflow_polys;

    logic signed [COORD_BITS-1:0] cur_x [DEF_MAX_VERTICES];
    logic signed [COORD_BITS-1:0] cur_y [DEF_MAX_VERTICES];
    int                           cur_nv;
    int                           cur_scale;

    always #5 clk = ~clk;

    point_in_polygon_test u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    pip_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic signed [COORD_BITS-1:0] rand_coord(input int scale);
        int v;
        if (scale >= 32768) begin
            return COORD_BITS'($urandom());
        end
        v = int'($urandom_range(2 * scale)) - scale;
        return v[COORD_BITS-1:0];
    endfunction

    task automatic send_item(input t_in_item item);
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        items_sent++;
        if (item.action == ACT_LOAD) begin
            n_loads++;
        end else begin
            n_queries++;
        end
        if (!(items_sent >= 600 && items_sent < 750) && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    task automatic send_load(input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y, input logic lst);
        if (cur_nv < DEF_MAX_VERTICES) begin
            cur_x[cur_nv] = x;
            cur_y[cur_nv] = y;
            cur_nv++;
        end
        send_item('{ACT_LOAD, x, y, lst});
    endtask

    task automatic send_query(input logic signed [COORD_BITS-1:0] x,
                              input logic signed [COORD_BITS-1:0] y, input logic lst);
        send_item('{ACT_QUERY, x, y, lst});
    endtask

    task automatic send_random_query();
        int r;
        int k;
        r = $urandom_range(99);
        if (cur_nv > 0 && r < 40) begin
            k = $urandom_range(cur_nv - 1);
            case ($urandom_range(2))
                0:       send_query(cur_x[k], cur_y[k], 1'($urandom_range(1)));
                1:       send_query(cur_x[k], rand_coord(cur_scale), 1'($urandom_range(1)));
                default: send_query(rand_coord(cur_scale), cur_y[k], 1'($urandom_range(1)));
            endcase
        end else if (r < 85) begin
            send_query(rand_coord(cur_scale), rand_coord(cur_scale), 1'($urandom_range(1)));
        end else begin
            send_query(rand_coord(32768), rand_coord(32768), 1'($urandom_range(1)));
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // receiver: random stalls, one quiet stretch, one long hold on request
    initial begin
        bit held;
        held      = 1'b0;
        out_ready = 1'b0;
        rx_cycle  = 0;
        forever begin
            @(negedge clk);
            rx_cycle++;
            if (hold_req && !held) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (399) @(negedge clk);
            end else if (rx_cycle >= 3000 && rx_cycle < 5000) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >= 30);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("timeout at %0t", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int  nv;
        int  nq;
        int  r;
        bit  closes;
        bit  mid_query;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        in_data          = '0;
        hold_req         = 1'b0;
        items_sent       = 0;
        n_loads          = 0;
        n_queries        = 0;
        n_polys          = 0;
        n_overflow_polys = 0;
        cur_nv           = 0;
        cur_scale        = 32768;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty store
        send_query(16'sd0, 16'sd0, 1'b0);
        // triangle at the coordinate extremes
        n_polys++;
        send_load(-16'sd32768, -16'sd32768, 1'b0);
        send_load(16'sd32767, -16'sd32768, 1'b0);
        send_load(16'sd0, 16'sd32767, 1'b1);
        send_query(16'sd0, 16'sd0, 1'b0);
        send_query(16'sd32767, 16'sd32767, 1'b0);
        send_query(-16'sd32768, -16'sd32768, 1'b0);
        send_query(16'sd0, -16'sd32768, 1'b0);
        send_query(-16'sd32768, 16'sd32767, 1'b1);
        // new polygon after a closed one, queried while still open
        n_polys++;
        cur_nv = 0;
        send_load(-16'sd10, -16'sd10, 1'b0);
        send_load(16'sd10, -16'sd10, 1'b0);
        send_load(16'sd10, 16'sd10, 1'b0);
        send_query(16'sd0, 16'sd0, 1'b0);
        send_load(-16'sd10, 16'sd10, 1'b1);
        send_query(16'sd0, 16'sd0, 1'b1);
        send_query(16'sd10, 16'sd0, 1'b0);
        send_query(-16'sd10, 16'sd0, 1'b0);
        send_query(16'sd0, 16'sd10, 1'b0);
        // single vertex polygon
        n_polys++;
        cur_nv = 0;
        send_load(16'sd5, 16'sd5, 1'b1);
        send_query(16'sd5, 16'sd5, 1'b0);
        send_query(16'sd4, 16'sd6, 1'b0);

        while (items_sent < N_ITEMS) begin
            n_polys++;
            if (n_polys == 15) begin
                hold_req = 1'b1;
            end
            if (n_polys == 30 || n_polys == 80) begin
                wait_idle();
            end
            r = $urandom_range(99);
            if (r < 5) begin
                nv = $urandom_range(60, 70);
            end else if (r < 12) begin
                nv = $urandom_range(1, 2);
            end else begin
                nv = $urandom_range(3, 12);
            end
            if (nv > DEF_MAX_VERTICES) begin
                n_overflow_polys++;
            end
            case ($urandom_range(3))
                0:       cur_scale = 8;
                1:       cur_scale = 100;
                2:       cur_scale = 2000;
                default: cur_scale = 32768;
            endcase
            closes    = ($urandom_range(9) != 0);
            mid_query = ($urandom_range(99) < 15);
            nq        = (n_polys == 15) ? 8 : $urandom_range(1, 6);
            cur_nv    = 0;
            for (int k = 0; k < nv; k++) begin
                if (mid_query && k == nv / 2) begin
                    send_random_query();
                end
                send_load(rand_coord(cur_scale), rand_coord(cur_scale), closes && k == nv - 1);
            end
            for (int k = 0; k < nq; k++) begin
                send_random_query();
            end
            // an open polygon gets closed so the next load starts afresh
            if (!closes) begin
                send_load(rand_coord(cur_scale), rand_coord(cur_scale), 1'b1);
            end
        end

        wait_idle();
        repeat (100) @(posedge clk);
        $display("covered %0d vertex loads and %0d point queries over %0d polygons",
                 n_loads, n_queries, n_polys);
        $display("%0d polygons overflowed the vertex store", n_overflow_polys);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
